// ===== rtl/u8sc_pkg.sv =====
`default_nettype none
package u8sc_pkg;

  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned BufDepth      = 4;

  localparam logic [7:0] LeadTwoMin   = 8'hc2;
  localparam logic [7:0] LeadThreeMin = 8'he0;
  localparam logic [7:0] LeadFourMin  = 8'hf0;
  localparam logic [7:0] LeadBadMin   = 8'hf5;
  localparam logic [7:0] E0FollowMin  = 8'ha0;
  localparam logic [7:0] F0FollowMin  = 8'h90;
  localparam logic [7:0] ContMask     = 8'hc0;
  localparam logic [7:0] ContTag      = 8'h80;
  localparam logic [7:0] LeadF4       = 8'hf4;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cur_len;
    logic       terminal;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/u8sc_datapath.sv =====
`default_nettype none
module u8sc_datapath #(
  parameter int unsigned COUNT_WIDTH = u8sc_pkg::CountWidthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_byte_value,
  input  wire logic              in_last_byte,
  input  wire u8sc_pkg::dp_cmd_t cmd,
  output u8sc_pkg::dp_sts_t      sts,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [2:0]             out_seq_len,
  output logic [31:0]            out_char_count,
  output logic                   out_string_done,
  output logic                   out_run_end
);
  import u8sc_pkg::*;

  function automatic logic [2:0] char_len(
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
    input logic [7:0] b3, input logic [2:0] avail, input logic last
  );
    logic [2:0] need;
    logic       bad;
    logic [2:0] res;
    need = 3'd1;
    bad  = 1'b0;
    if (b0 < LeadTwoMin || b0 >= LeadBadMin) begin
      res = 3'd1;
    end else begin
      if (b0 < LeadThreeMin) need = 3'd2;
      else if (b0 < LeadFourMin) need = 3'd3;
      else need = 3'd4;
      if (avail > 3'd1) begin
        if ((b1 & ContMask) != ContTag) bad = 1'b1;
        if (b0 == LeadThreeMin && b1 < E0FollowMin) bad = 1'b1;
        if (b0 == LeadFourMin && b1 < F0FollowMin) bad = 1'b1;
        if (b0 == LeadF4 && b1 >= F0FollowMin) bad = 1'b1;
      end
      if (avail > 3'd2 && need > 3'd2 && (b2 & ContMask) != ContTag) bad = 1'b1;
      if (avail > 3'd3 && need > 3'd3 && (b3 & ContMask) != ContTag) bad = 1'b1;
      if (bad) res = 3'd1;
      else if (avail >= need) res = need;
      else res = last ? 3'd1 : 3'd0;
    end
    return res;
  endfunction

  logic [BufDepth-1:0][7:0] buf_r, buf_nxt;
  logic [2:0]               cnt_r, cnt_nxt;
  logic [2:0]               pos_r, pos_nxt;
  logic                     last_r, last_nxt;
  logic [COUNT_WIDTH-1:0]   total_r, total_nxt, total_inc;
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               out_len_r;
  logic [31:0]              out_count_r;
  logic                     out_done_r, out_end_r;

  logic [BufDepth-1:0][2:0] len_at;
  logic [2:0]               next_pos, pos_final;
  logic [63:0]              total_ext;

  always_comb begin
    for (int p = 0; p < BufDepth; p++) begin
      logic [7:0] bb [4];
      logic [2:0] av;
      for (int i = 0; i < 4; i++) begin
        bb[i] = (p + i < BufDepth) ? buf_r[p + i] : 8'h00;
      end
      av = (3'(p) < cnt_r) ? cnt_r - 3'(p) : 3'd0;
      len_at[p] = char_len(bb[0], bb[1], bb[2], bb[3], av, last_r);
    end
  end

  assign sts.cur_len = len_at[pos_r[1:0]];
  assign next_pos    = pos_r + len_at[pos_r[1:0]];
  assign sts.terminal = (next_pos >= cnt_r) || (len_at[next_pos[1:0]] == 3'd0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign total_inc = (total_r == {COUNT_WIDTH{1'b1}}) ? total_r : total_r + 1'b1;
  assign total_ext = 64'(total_inc);
  assign pos_final = cmd.emit ? next_pos : pos_r;

  always_comb begin
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      buf_nxt[cnt_r[1:0]] = in_byte_value;
      cnt_nxt  = cnt_r + 3'd1;
      pos_nxt  = 3'd0;
      last_nxt = in_last_byte;
    end
    if (cmd.emit) begin
      pos_nxt       = next_pos;
      total_nxt     = total_inc;
      out_valid_nxt = 1'b1;
    end
    if (cmd.finish) begin
      // drop consumed bytes, keep the pending tail at the front
      for (int k = 0; k < BufDepth; k++) begin
        if (32'(pos_final) + 32'(k) < BufDepth) buf_nxt[k] = buf_r[2'(3'(k) + pos_final)];
      end
      cnt_nxt = last_r ? 3'd0 : cnt_r - pos_final;
      pos_nxt = 3'd0;
      if (last_r) total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    last_r <= last_nxt;
    if (cmd.emit) begin
      out_len_r   <= sts.cur_len;
      out_count_r <= total_ext[31:0];
      out_end_r   <= sts.terminal;
      out_done_r  <= sts.terminal && last_r;
    end
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      pos_r       <= 3'd0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seq_len     = out_len_r;
  assign out_char_count  = out_count_r;
  assign out_string_done = out_done_r;
  assign out_run_end     = out_end_r;

endmodule
`default_nettype wire

// ===== rtl/u8sc_ctrl.sv =====
`default_nettype none
module u8sc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire u8sc_pkg::dp_sts_t sts,
  output u8sc_pkg::dp_cmd_t      cmd
);
  import u8sc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.cur_len == 3'd0) begin
          // prefix still waiting for followers
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.terminal) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf8_sequence_counter_core.sv =====
`default_nettype none
// a byte is loaded in the idle state; its results are registered from the scan state
// the input is stalled in the scan state, so no new byte is taken until every result of the
//   last byte has been emitted; an output stall holds the scan state
// a waiting prefix gives no result
// synchronous active-low reset clears the held byte count, the running count and out_valid
module utf8_sequence_counter_core #(
  parameter int unsigned COUNT_WIDTH = u8sc_pkg::CountWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_seq_len,
  output logic [31:0]      out_char_count,
  output logic             out_string_done,
  output logic             out_run_end
);
  import u8sc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  u8sc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8sc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_seq_len     (out_seq_len),
    .out_char_count  (out_char_count),
    .out_string_done (out_string_done),
    .out_run_end     (out_run_end)
  );

endmodule
`default_nettype wire

// ===== tb/utf8_sequence_counter_core_test.sv =====
`default_nettype none
module utf8_sequence_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sc_pkg::*;

  typedef struct packed {
    logic [2:0]  seq_len;
    logic [31:0] char_count;
    logic        string_done;
    logic        run_end;
  } char_beat_t;

  // how a generated character is shaped
  typedef enum int {
    CharGood,
    CharRandom,
    CharCut,
    CharBadFollow
  } char_kind_t;

  localparam int unsigned LongHoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_seq_len;
  logic [31:0] out_char_count;
  logic        out_string_done;
  logic        out_run_end;

  // predictor state: bytes of an unfinished sequence and the running count
  logic [2:0][7:0] held_bytes = '0;
  int unsigned     held_n = 0;
  logic [31:0]     char_total = '0;

  char_beat_t  expected_chars[$];
  logic [7:0]  str_q[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  utf8_sequence_counter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_seq_len     (out_seq_len),
    .out_char_count  (out_char_count),
    .out_string_done (out_string_done),
    .out_run_end     (out_run_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // length of the character starting at w[p]; 0 means wait for more bytes
  function automatic int unsigned char_len(input logic [3:0][7:0] w, input int unsigned p,
                                           input int unsigned avail, input bit last);
    logic [7:0]  lead;
    int unsigned need;
    lead = w[p];
    if (lead < LeadTwoMin) return 1;
    if (lead < LeadThreeMin) need = 2;
    else if (lead < LeadFourMin) need = 3;
    else if (lead < LeadBadMin) need = 4;
    else return 1;
    for (int unsigned i = 1; i < need && i < avail; i++) begin
      if ((w[p+i] & ContMask) != ContTag) return 1;
      if (i == 1) begin
        if (lead == LeadThreeMin && w[p+1] < E0FollowMin) return 1;
        if (lead == LeadFourMin && w[p+1] < F0FollowMin) return 1;
        if (lead == LeadF4 && w[p+1] >= F0FollowMin) return 1;
      end
    end
    if (avail >= need) return need;
    return last ? 1 : 0;
  endfunction

  task automatic split_byte(input logic [7:0] b, input bit last);
    logic [3:0][7:0] w;
    char_beat_t      got [4];
    int unsigned     n, pos, len, cnt;
    w = '0;
    cnt = 0;
    pos = 0;
    for (int unsigned k = 0; k < held_n; k++) w[k] = held_bytes[k];
    w[held_n] = b;
    n = held_n + 1;
    while (pos < n && cnt < 4) begin
      len = char_len(w, pos, n - pos, last);
      if (len == 0) break;
      pos += len;
      if (char_total != 32'hffff_ffff) char_total++;
      got[cnt].seq_len = len[2:0];
      got[cnt].char_count = char_total;
      got[cnt].string_done = 1'b0;
      got[cnt].run_end = 1'b0;
      cnt++;
    end
    held_n = n - pos;
    for (int unsigned k = 0; k < held_n; k++) held_bytes[k] = w[pos+k];
    if (cnt > 0) begin
      got[cnt-1].run_end = 1'b1;
      got[cnt-1].string_done = last;
    end
    if (last) begin
      char_total = '0;
      held_n = 0;
    end
    for (int unsigned k = 0; k < cnt; k++) expected_chars.push_back(got[k]);
  endtask

  // called at a rising edge; returns at the edge where the beat is taken, or after a random idle gap that follows it
  task automatic push_byte(input logic [7:0] b, input bit last);
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    split_byte(b, last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_string();
    foreach (str_q[i]) push_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic add_char(input char_kind_t kind);
    logic [7:0]  c[$];
    int unsigned len;
    logic [7:0]  lead;
    len = $urandom_range(1, 4);
    case (len)
      1: c.push_back(8'($urandom_range(8'h00, 8'h7f)));
      2: c.push_back(8'($urandom_range(LeadTwoMin, 8'hdf)));
      3: c.push_back(8'($urandom_range(LeadThreeMin, 8'hef)));
      default: c.push_back(8'($urandom_range(LeadFourMin, LeadF4)));
    endcase
    lead = c[0];
    if (len > 1) begin
      if (lead == LeadThreeMin) c.push_back(8'($urandom_range(E0FollowMin, 8'hbf)));
      else if (lead == LeadFourMin) c.push_back(8'($urandom_range(F0FollowMin, 8'hbf)));
      else if (lead == LeadF4) c.push_back(8'($urandom_range(ContTag, 8'h8f)));
      else c.push_back(8'($urandom_range(ContTag, 8'hbf)));
    end
    while (c.size() < len) c.push_back(8'($urandom_range(ContTag, 8'hbf)));
    case (kind)
      CharRandom: begin
        c.delete();
        c.push_back(8'($urandom_range(0, 255)));
      end
      CharCut: if (c.size() > 1) repeat ($urandom_range(1, c.size() - 1)) void'(c.pop_back());
      CharBadFollow: c[$urandom_range(0, c.size() - 1)] = 8'($urandom_range(0, 255));
      default: ;
    endcase
    foreach (c[i]) str_q.push_back(c[i]);
  endtask

  task automatic send_random_bytes(input int unsigned total);
    int unsigned sent;
    int          roll;
    sent = 0;
    while (sent < total) begin
      repeat ($urandom_range(1, 6)) begin
        roll = $urandom_range(0, 9);
        add_char(roll < 7 ? CharGood : char_kind_t'(roll - 6));
      end
      sent += str_q.size();
      send_string();
    end
  endtask

  task automatic test_directed();
    str_q = '{8'h00};
    send_string();
    str_q = '{8'h7f, 8'h80, 8'hbf, 8'hc1};
    send_string();
    str_q = '{8'hc2, 8'h80, 8'hdf, 8'hbf};
    send_string();
    // overlong three-byte form rejected early
    str_q = '{8'he0, 8'ha0, 8'h80, 8'he0, 8'h9f, 8'h41};
    send_string();
    // surrogate lead is accepted
    str_q = '{8'hed, 8'ha0, 8'h80, 8'hef, 8'hbf, 8'hbf};
    send_string();
    str_q = '{8'hf0, 8'h90, 8'h80, 8'h80, 8'hf0, 8'h8f};
    send_string();
    // above the code point limit, then bytes that never start a sequence
    str_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hf4, 8'h90, 8'hf5, 8'hff};
    send_string();
    str_q = '{8'he1, 8'h80, 8'h41};
    send_string();
    // four-byte prefix broken by a lead, then the lead is cut by the string end
    str_q = '{8'hf1, 8'h80, 8'h80, 8'hc2};
    send_string();
  endtask

  task automatic test_random();
    send_random_bytes(300);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) begin
      str_q.push_back(8'hf1);
      str_q.push_back(8'h80);
      str_q.push_back(8'h80);
      str_q.push_back(8'h41);
    end
    send_string();
  endtask

  task automatic test_steady();
    calm = 1'b1;
    send_random_bytes(60);
  endtask

  // result checker
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: len %0d count %0d done %0b run_end %0b",
                   out_seq_len, out_char_count, out_string_done, out_run_end);
      end else begin
        want = expected_chars.pop_front();
        if (out_seq_len !== want.seq_len || out_char_count !== want.char_count ||
            out_string_done !== want.string_done || out_run_end !== want.run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp len %0d count %0d done %0b run_end %0b, got %0d %0d %0b %0b",
                     want.seq_len, want.char_count, want.string_done, want.run_end,
                     out_seq_len, out_char_count, out_string_done, out_run_end);
        end
      end
    end
  end

  // receiver side: random stall bursts plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_left = LongHoldCycles;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_steady();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_chars.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
